>>> design/tslc_pkg.sv
// Shared types, character codes and helper functions of the touch switch controller.
`default_nettype none

package tslc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int ANN_LEN     = 8;

  // Event kinds carried in the mode field
  localparam logic [1:0] EV_BYTE    = 2'd0;
  localparam logic [1:0] EV_TICK    = 2'd1;
  localparam logic [1:0] EV_PRESS   = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // Register indexes on the APB port
  localparam logic [2:0] REG_ACK_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] REG_DARK_START  = 3'd2;
  localparam logic [2:0] REG_CONFIG_END  = 3'd3;
  localparam logic [2:0] REG_BLINK_HALF  = 3'd4;

  // Character codes
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_C = 8'h43;

  // Both-outer-buttons hold mask
  localparam logic [3:0] HOLD_MASK = 4'b1001;

  // Announcement sent on config entry
  localparam logic [7:0] ANNOUNCE [ANN_LEN] = '{
    8'h50, 8'h49, 8'h43, 8'h53, 8'h4D, 8'h41, 8'h52, 8'h54
  };

  typedef enum logic [1:0] {
    TX_NONE,
    TX_ECHO,
    TX_REPORT,
    TX_ANNOUNCE
  } tx_kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [1:0] button;
  } event_t;

  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [15:0] long_press;
    logic [15:0] dark_start;
    logic [15:0] config_end;
    logic [7:0]  blink_half;
  } cfg_t;

  // One queued job: patterns after the event plus what to transmit
  typedef struct packed {
    logic [3:0] led;
    logic [3:0] relay;
    tx_kind_t   kind;
    logic [7:0] echo;
  } job_t;

  typedef struct packed {
    logic [3:0] led_pattern;
    logic [3:0] relay_pattern;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } pat_t;

  function automatic pat_t pattern_of(input logic [7:0] b);
    pat_t p;
    p.hit = 1'b1;
    p.idx = 4'd0;
    unique case (b) inside
      [CH_0:CH_9]: p.idx = b[3:0];
      [CH_A:CH_E]: p.idx = b[3:0] + 4'd9;
      CH_G:        p.idx = 4'd15;
      default:     p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(input logic [3:0] idx);
    logic [7:0] c;
    if (idx <= 4'd9) begin
      c = {4'h3, idx};
    end else if (idx == 4'd15) begin
      c = CH_G;
    end else begin
      c = 8'h37 + {4'h0, idx};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/tslc_in_if.sv
// Event channel interface: valid/ready plus one event word.
`default_nettype none

interface tslc_in_if;
  import tslc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  logic [1:0] button;

  modport source (output valid, mode, rx_byte, button, input ready);
  modport sink   (input valid, mode, rx_byte, button, output ready);
endinterface

`default_nettype wire

>>> design/tslc_out_if.sv
// Result channel interface: valid/ready plus one result word.
`default_nettype none

interface tslc_out_if;
  import tslc_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] led_pattern;
  logic [3:0] relay_pattern;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, led_pattern, relay_pattern, tx_valid, tx_byte, last,
                  input ready);
  modport sink   (input valid, led_pattern, relay_pattern, tx_valid, tx_byte, last,
                  output ready);
endinterface

`default_nettype wire

>>> design/tslc_front.sv
// Event front end: holds the switch state, applies one event per cycle while ev_take is high, emits a job.
`default_nettype none

module tslc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tslc_pkg::cfg_t   cfg,
  input  wire logic            ev_take,
  input  wire tslc_pkg::event_t ev,
  output tslc_pkg::job_t        job
);
  import tslc_pkg::*;

  logic [3:0]  relay_r, relay_nxt;
  logic [3:0]  led_r, led_nxt;
  logic [3:0]  pressed_r, pressed_nxt;
  logic        cfg_mode_r, cfg_mode_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic        blink_on_r, blink_on_nxt;
  logic [7:0]  blink_cnt_r, blink_cnt_nxt;
  tx_kind_t    kind;

  logic [15:0] wait_inc, wait_inc2, hold_inc;
  logic [7:0]  blink_inc;
  logic [3:0]  bit_sel;
  pat_t        rx_pat, held_pat;
  logic        rx_ok, rx_tf;

  assign wait_inc  = wait_r + 16'd1;
  assign wait_inc2 = wait_r + 16'd2;
  assign hold_inc  = hold_r + 16'd1;
  assign blink_inc = blink_cnt_r + 8'd1;
  assign bit_sel   = 4'b0001 << ev.button;
  assign rx_pat    = pattern_of(ev.rx_byte);
  assign held_pat  = pattern_of(held_r);
  assign rx_tf     = (ev.rx_byte == CH_T) || (ev.rx_byte == CH_F);
  assign rx_ok     = rx_pat.hit || rx_tf || (ev.rx_byte == CH_U);

  always_comb begin
    relay_nxt     = relay_r;
    led_nxt       = led_r;
    pressed_nxt   = pressed_r;
    cfg_mode_nxt  = cfg_mode_r;
    await_nxt     = await_r;
    held_nxt      = held_r;
    wait_nxt      = wait_r;
    hold_nxt      = hold_r;
    blink_on_nxt  = blink_on_r;
    blink_cnt_nxt = blink_cnt_r;
    kind          = TX_NONE;

    unique case (ev.mode)
      EV_BYTE: begin
        if (rx_ok) begin
          if (!await_r) begin
            held_nxt = ev.rx_byte;
            if (!rx_tf) begin
              kind      = TX_ECHO;
              await_nxt = 1'b1;
              wait_nxt  = 16'd0;
            end
          end else if (cfg_mode_r) begin
            if (rx_tf) begin
              cfg_mode_nxt = 1'b0;
              await_nxt    = 1'b0;
              led_nxt      = relay_r;
            end
          end else if (ev.rx_byte == CH_T) begin
            if (held_pat.hit) begin
              relay_nxt = held_pat.idx;
              led_nxt   = held_pat.idx;
              await_nxt = 1'b0;
            end else if (held_r == CH_U) begin
              kind = TX_REPORT;
            end else begin
              await_nxt = 1'b0;
            end
          end else if (ev.rx_byte == CH_F) begin
            await_nxt = 1'b0;
          end
        end
      end
      EV_TICK: begin
        if (!cfg_mode_r) begin
          if (await_r) begin
            if (wait_inc >= cfg.ack_timeout) begin
              wait_nxt  = 16'd0;
              await_nxt = 1'b0;
            end else begin
              wait_nxt = wait_inc;
            end
          end
          if (pressed_r == HOLD_MASK) begin
            if (hold_inc >= cfg.long_press) begin
              hold_nxt     = 16'd0;
              kind         = TX_ANNOUNCE;
              cfg_mode_nxt = 1'b1;
              await_nxt    = 1'b1;
              wait_nxt     = 16'd0;
              led_nxt      = 4'd0;
              blink_on_nxt = 1'b0;
            end else begin
              hold_nxt = hold_inc;
            end
          end else begin
            hold_nxt = 16'd0;
          end
        end else if (await_r && (wait_inc > cfg.dark_start) &&
                     (wait_inc2 >= cfg.config_end)) begin
          // config timeout: leave, no blink on this tick
          wait_nxt     = 16'd0;
          cfg_mode_nxt = 1'b0;
          await_nxt    = 1'b0;
          led_nxt      = relay_r;
        end else begin
          if (await_r) begin
            wait_nxt = (wait_inc > cfg.dark_start) ? wait_inc2 : wait_inc;
          end
          led_nxt = blink_on_r ? 4'hF : 4'h0;
          if (blink_inc >= cfg.blink_half) begin
            blink_cnt_nxt = 8'd0;
            blink_on_nxt  = !blink_on_r;
          end else begin
            blink_cnt_nxt = blink_inc;
          end
        end
      end
      EV_PRESS: begin
        pressed_nxt = pressed_r | bit_sel;
        hold_nxt    = 16'd0;
        if (!cfg_mode_r) begin
          relay_nxt = relay_r ^ bit_sel;
          led_nxt   = relay_r ^ bit_sel;
        end
      end
      EV_RELEASE: begin
        pressed_nxt = pressed_r & ~bit_sel;
        hold_nxt    = 16'd0;
        if (!cfg_mode_r && ((pressed_r & ~bit_sel & 4'b0111) == 4'd0)) begin
          kind = TX_REPORT;
        end
      end
      default: begin
      end
    endcase
  end

  assign job.led   = led_nxt;
  assign job.relay = relay_nxt;
  assign job.kind  = kind;
  assign job.echo  = ev.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= '0;
      led_r       <= '0;
      pressed_r   <= '0;
      cfg_mode_r  <= 1'b0;
      await_r     <= 1'b0;
      held_r      <= '0;
      wait_r      <= '0;
      hold_r      <= '0;
      blink_on_r  <= 1'b0;
      blink_cnt_r <= '0;
    end else if (ev_take) begin
      relay_r     <= relay_nxt;
      led_r       <= led_nxt;
      pressed_r   <= pressed_nxt;
      cfg_mode_r  <= cfg_mode_nxt;
      await_r     <= await_nxt;
      held_r      <= held_nxt;
      wait_r      <= wait_nxt;
      hold_r      <= hold_nxt;
      blink_on_r  <= blink_on_nxt;
      blink_cnt_r <= blink_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/tslc_queue.sv
// Short job queue between the front end and the transmit back end.
`default_nettype none

module tslc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tslc_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output tslc_pkg::job_t      head_job
);
  import tslc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/tslc_back.sv
// Transmit back end: expands each job into one to eight result words.
`default_nettype none

module tslc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire tslc_pkg::job_t   head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tslc_pkg::out_word_t   out_word
);
  import tslc_pkg::*;

  logic      busy_r, busy_nxt;
  job_t      job_r;
  logic [2:0] idx_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t word_r;

  job_t       cur_job;
  logic [2:0] cur_idx;
  logic       adv;
  out_word_t  word;

  function automatic out_word_t make_word(input job_t j, input logic [2:0] k);
    out_word_t w;
    w.led_pattern   = j.led;
    w.relay_pattern = j.relay;
    w.tx_valid      = 1'b1;
    w.tx_byte       = 8'h00;
    w.last          = 1'b1;
    unique case (j.kind)
      TX_NONE: begin
        w.tx_valid = 1'b0;
      end
      TX_ECHO: begin
        w.tx_byte = j.echo;
      end
      TX_REPORT: begin
        case (k)
          3'd0:    w.tx_byte = CH_P;
          3'd1:    w.tx_byte = CH_I;
          3'd2:    w.tx_byte = CH_C;
          default: w.tx_byte = code_char(j.relay);
        endcase
        w.last = (k == 3'd3);
      end
      TX_ANNOUNCE: begin
        w.tx_byte = ANNOUNCE[k];
        w.last    = (k == 3'(ANN_LEN - 1));
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  assign cur_job = busy_r ? job_r : head_job;
  assign cur_idx = busy_r ? idx_r : 3'd0;
  assign adv     = (busy_r || head_valid) && (!out_valid_r || out_ready);
  assign word    = make_word(cur_job, cur_idx);
  assign pop     = adv && !busy_r;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      busy_nxt      = !word.last;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r  <= cur_job;
      idx_r  <= cur_idx + 3'd1;
      word_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = word_r;

  // only multi-word jobs stay in progress
  a_busy_kind: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.kind == TX_REPORT || job_r.kind == TX_ANNOUNCE))
    else $error("back end busy on a single-word job");

  a_busy_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != 3'd0))
    else $error("back end busy with word index zero");

  a_report_len: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && job_r.kind == TX_REPORT) |-> (idx_r <= 3'd3))
    else $error("report ran past four words");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head_job.kind == TX_NONE || head_job.kind == TX_ECHO)) |=> !busy_r)
    else $error("single-word job left back end busy");

endmodule

`default_nettype wire

>>> design/touch_switch_link_controller.sv
// Top level of the four-gang touch switch link controller with its APB register file.
//
//  channel   dir  handshake            word
//  in_ch     in   valid/ready          mode, rx_byte, button
//  out_ch    out  valid/ready          led_pattern, relay_pattern, tx_valid, tx_byte, last
//  apb       in   psel/penable/pready  5 regs at 4*i, pready tied high
//
// Front end takes one event per cycle while the job queue has room; its state update is
// registered. Back end sends one result word per cycle unless stalled: 1 word for a quiet
// or echo event, 4 for a report, 8 for the config announcement, so the output channel sets
// the rate. Synchronous active-low reset; the APB registers return to their defaults.
// A stalled output holds its word; the front keeps taking events until the queue fills.
`default_nettype none

module touch_switch_link_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tslc_in_if.sink          in_ch,
  tslc_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tslc_pkg::*;

  // register file: to be written only while idle, by the user; the block does not enforce it
  logic [15:0] ack_timeout_r, long_press_r, dark_start_r, config_end_r;
  logic [7:0]  blink_half_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  cfg_t        cfg;

  event_t    ev;
  logic      ev_take;
  job_t      front_job;
  logic      q_full, q_valid, q_pop;
  job_t      q_head;
  logic      back_valid;
  out_word_t back_word;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= 16'd20;
      long_press_r  <= 16'd1500;
      dark_start_r  <= 16'd30000;
      config_end_r  <= 16'd32000;
      blink_half_r  <= 8'd200;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ACK_TIMEOUT: ack_timeout_r <= pwdata[15:0];
        REG_LONG_PRESS:  long_press_r  <= pwdata[15:0];
        REG_DARK_START:  dark_start_r  <= pwdata[15:0];
        REG_CONFIG_END:  config_end_r  <= pwdata[15:0];
        REG_BLINK_HALF:  blink_half_r  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_r};
      REG_LONG_PRESS:  prdata = {16'd0, long_press_r};
      REG_DARK_START:  prdata = {16'd0, dark_start_r};
      REG_CONFIG_END:  prdata = {16'd0, config_end_r};
      REG_BLINK_HALF:  prdata = {24'd0, blink_half_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.ack_timeout = ack_timeout_r;
  assign cfg.long_press  = long_press_r;
  assign cfg.dark_start  = dark_start_r;
  assign cfg.config_end  = config_end_r;
  assign cfg.blink_half  = blink_half_r;

  // event intake: accepted whenever the queue can take the job
  assign ev.mode    = in_ch.mode;
  assign ev.rx_byte = in_ch.rx_byte;
  assign ev.button  = in_ch.button;
  assign in_ch.ready = !q_full;
  assign ev_take     = in_ch.valid && !q_full;

  tslc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .ev_take (ev_take),
    .ev      (ev),
    .job     (front_job)
  );

  tslc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_take),
    .push_job   (front_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  tslc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (back_valid),
    .out_ready  (out_ch.ready),
    .out_word   (back_word)
  );

  assign out_ch.valid         = back_valid;
  assign out_ch.led_pattern   = back_word.led_pattern;
  assign out_ch.relay_pattern = back_word.relay_pattern;
  assign out_ch.tx_valid      = back_word.tx_valid;
  assign out_ch.tx_byte       = back_word.tx_byte;
  assign out_ch.last          = back_word.last;

endmodule

`default_nettype wire

>>> verif/tslc_checker.sv
`timescale 1ns / 1ps
// Checker for the touch switch controller: predicts result words and compares them.
module tslc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tslc_in_if               in_mon,
  tslc_out_if              out_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  output int               errors,
  output int               pending,
  output int               words_checked,
  output int               setup_entries
);
  import tslc_pkg::*;

  localparam logic [15:0] DEF_ACK   = 16'd20;
  localparam logic [15:0] DEF_HOLD  = 16'd1500;
  localparam logic [15:0] DEF_DARK  = 16'd30000;
  localparam logic [15:0] DEF_END   = 16'd32000;
  localparam logic [7:0]  DEF_BLINK = 8'd200;
  localparam int          MAX_PRINTS = 40;

  // register copies
  logic [15:0] ack_limit, hold_limit, dark_from, setup_end;
  logic [7:0]  blink_len;

  // controller state copy
  logic [3:0]  relay_q, led_q, held_mask;
  logic        in_setup, confirm_wait, blink_lit;
  logic [7:0]  held_byte, blink_ticks;
  logic [15:0] wait_ticks, hold_ticks;

  logic [7:0]  tx_bytes [$];
  out_word_t   expected_words [$];

  task automatic flag(input string what);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH at %0t, word %0d: %s", $time, words_checked, what);
  endtask

  function automatic bit pattern_index(input logic [7:0] b, output logic [3:0] idx);
    idx = 4'd0;
    if (b >= CH_0 && b <= CH_9) begin
      idx = 4'(b - CH_0);
      return 1'b1;
    end
    if (b >= CH_A && b <= CH_E) begin
      idx = 4'(b - CH_A + 8'd10);
      return 1'b1;
    end
    if (b == CH_G) begin
      idx = 4'd15;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] pattern_code(input logic [3:0] p);
    if (p <= 4'd9) return CH_0 + 8'(p);
    if (p == 4'd15) return CH_G;
    return CH_A + 8'(p - 4'd10);
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_ACK_TIMEOUT: return {16'd0, ack_limit};
      REG_LONG_PRESS:  return {16'd0, hold_limit};
      REG_DARK_START:  return {16'd0, dark_from};
      REG_CONFIG_END:  return {16'd0, setup_end};
      REG_BLINK_HALF:  return {24'd0, blink_len};
      default:         return 32'd0;
    endcase
  endfunction

  task automatic reset_model();
    ack_limit = DEF_ACK;
    hold_limit = DEF_HOLD;
    dark_from = DEF_DARK;
    setup_end = DEF_END;
    blink_len = DEF_BLINK;
    relay_q = '0;
    led_q = '0;
    held_mask = '0;
    in_setup = 1'b0;
    confirm_wait = 1'b0;
    blink_lit = 1'b0;
    held_byte = '0;
    blink_ticks = '0;
    wait_ticks = '0;
    hold_ticks = '0;
    expected_words.delete();
  endtask

  task automatic queue_report();
    tx_bytes.push_back(CH_P);
    tx_bytes.push_back(CH_I);
    tx_bytes.push_back(CH_C);
    tx_bytes.push_back(pattern_code(relay_q));
  endtask

  task automatic leave_setup();
    in_setup = 1'b0;
    confirm_wait = 1'b0;
    led_q = relay_q;
  endtask

  task automatic byte_in(input logic [7:0] b);
    logic [3:0] p;
    bit         hit;
    hit = pattern_index(b, p);
    if (hit || b == CH_T || b == CH_F || b == CH_U) begin
      if (!confirm_wait) begin
        held_byte = b;
        if (b != CH_T && b != CH_F) begin
          tx_bytes.push_back(b);
          confirm_wait = 1'b1;
          wait_ticks = '0;
        end
      end else if (in_setup) begin
        if (b == CH_T || b == CH_F) leave_setup();
      end else if (b == CH_T) begin
        if (pattern_index(held_byte, p)) begin
          relay_q = p;
          led_q = p;
          confirm_wait = 1'b0;
        end else if (held_byte == CH_U) begin
          queue_report();
        end else begin
          confirm_wait = 1'b0;
        end
      end else if (b == CH_F) begin
        confirm_wait = 1'b0;
      end
    end
  endtask

  task automatic tick_in();
    bit abandoned;
    abandoned = 1'b0;
    if (!in_setup) begin
      if (confirm_wait) begin
        wait_ticks = wait_ticks + 16'd1;
        if (wait_ticks >= ack_limit) begin
          wait_ticks = '0;
          confirm_wait = 1'b0;
        end
      end
      if (held_mask == HOLD_MASK) begin
        hold_ticks = hold_ticks + 16'd1;
        if (hold_ticks >= hold_limit) begin
          hold_ticks = '0;
          for (int i = 0; i < ANN_LEN; i++) tx_bytes.push_back(ANNOUNCE[i]);
          in_setup = 1'b1;
          confirm_wait = 1'b1;
          wait_ticks = '0;
          led_q = '0;
          blink_lit = 1'b0;
          setup_entries++;
        end
      end else begin
        hold_ticks = '0;
      end
    end else begin
      if (confirm_wait) begin
        wait_ticks = wait_ticks + 16'd1;
        if (wait_ticks > dark_from) begin
          led_q = '0;
          wait_ticks = wait_ticks + 16'd1;
          if (wait_ticks >= setup_end) begin
            wait_ticks = '0;
            leave_setup();
            abandoned = 1'b1;
          end
        end
      end
      // no blink on the tick that gives up setup mode
      if (!abandoned) begin
        blink_ticks = blink_ticks + 8'd1;
        led_q = blink_lit ? 4'hF : 4'h0;
        if (blink_ticks >= blink_len) begin
          blink_ticks = '0;
          blink_lit = !blink_lit;
        end
      end
    end
  endtask

  task automatic predict_event(input event_t ev);
    logic [3:0] btn_bit;
    out_word_t  w;
    btn_bit = 4'b0001 << ev.button;
    tx_bytes.delete();
    case (ev.mode)
      EV_BYTE: byte_in(ev.rx_byte);
      EV_TICK: tick_in();
      EV_PRESS: begin
        held_mask = held_mask | btn_bit;
        hold_ticks = '0;
        if (!in_setup) begin
          relay_q = relay_q ^ btn_bit;
          led_q = relay_q;
        end
      end
      default: begin
        held_mask = held_mask & ~btn_bit;
        hold_ticks = '0;
        if (!in_setup && held_mask[2:0] == 3'b000) queue_report();
      end
    endcase
    w.led_pattern = led_q;
    w.relay_pattern = relay_q;
    if (tx_bytes.size() == 0) begin
      w.tx_valid = 1'b0;
      w.tx_byte = '0;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      foreach (tx_bytes[k]) begin
        w.tx_valid = 1'b1;
        w.tx_byte = tx_bytes[k];
        w.last = (k == tx_bytes.size() - 1);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic compare_word();
    out_word_t want;
    if (expected_words.size() == 0) begin
      flag("result word with nothing expected");
    end else begin
      want = expected_words.pop_front();
      if (out_mon.led_pattern !== want.led_pattern)
        flag($sformatf("led_pattern %h, want %h", out_mon.led_pattern, want.led_pattern));
      if (out_mon.relay_pattern !== want.relay_pattern)
        flag($sformatf("relay_pattern %h, want %h", out_mon.relay_pattern,
                       want.relay_pattern));
      if (out_mon.tx_valid !== want.tx_valid)
        flag($sformatf("tx_valid %b, want %b", out_mon.tx_valid, want.tx_valid));
      if (out_mon.tx_byte !== want.tx_byte)
        flag($sformatf("tx_byte %h, want %h", out_mon.tx_byte, want.tx_byte));
      if (out_mon.last !== want.last)
        flag($sformatf("last %b, want %b", out_mon.last, want.last));
    end
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_ACK_TIMEOUT: ack_limit = pwdata[15:0];
            REG_LONG_PRESS:  hold_limit = pwdata[15:0];
            REG_DARK_START:  dark_from = pwdata[15:0];
            REG_CONFIG_END:  setup_end = pwdata[15:0];
            REG_BLINK_HALF:  blink_len = pwdata[7:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[4:2])) begin
          flag($sformatf("register %0d reads %h, want %h", paddr[4:2], prdata,
                         reg_value(paddr[4:2])));
        end
      end
      // new expectations first; a word leaving now is always older
      if (in_mon.valid && in_mon.ready)
        predict_event('{mode: in_mon.mode, rx_byte: in_mon.rx_byte, button: in_mon.button});
      if (out_mon.valid && out_mon.ready) compare_word();
    end
    pending = expected_words.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the touch switch controller testbench: clock, reset, stimulus and verdict.
module tb;
  import tslc_pkg::*;

  localparam int PHASE_ITEMS = 55;   // random events per register setting
  localparam int NUM_PHASES  = 6;
  localparam int IDLE_PCT    = 10;   // chance of a gap or stall, in percent
  localparam int END_CYCLES  = 32;   // quiet cycles after the last word

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic sink_ready = 1'b0;
  logic calm = 1'b0;         // high: neither side idles

  int errors;
  int pending;
  int words_checked;
  int setup_entries;
  int events_sent = 0;

  // stimulus-side view of which buttons are held, to steer the long press
  logic [3:0]  btn_down = '0;
  logic [15:0] ack_set = 16'd20;
  logic [15:0] long_set = 16'd1500;
  logic [15:0] end_set = 16'd32000;

  tslc_in_if  in_ch ();
  tslc_out_if out_ch ();

  touch_switch_link_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tslc_checker link_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .setup_entries (setup_entries)
  );

  always #10 clk = ~clk;

  // Result side: random stalls, none while calm.
  assign out_ch.ready = sink_ready;
  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // 0-9: digits, 10-14: A-E, 15: G, 16: U
  function automatic logic [7:0] command_char(input int k);
    if (k <= 9) return CH_0 + 8'(k);
    if (k <= 14) return CH_A + 8'(k - 10);
    if (k == 15) return CH_G;
    return CH_U;
  endfunction

  function automatic int capped(input int v, input int cap);
    return (v > cap) ? cap : v;
  endfunction

  // One event word; returns at the edge where it was taken.
  task automatic put_event(input logic [1:0] m, input logic [7:0] b, input logic [1:0] btn);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.rx_byte <= b;
    in_ch.button  <= btn;
    do @(posedge clk); while (!in_ch.ready);
    if (m == EV_PRESS) btn_down[btn] = 1'b1;
    else if (m == EV_RELEASE) btn_down[btn] = 1'b0;
    events_sent++;
  endtask

  // Unused fields carry random bits so every input bit toggles.
  task automatic send_tick();
    put_event(EV_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    put_event(EV_BYTE, b, 2'($urandom_range(0, 3)));
  endtask

  task automatic push_button(input logic [1:0] btn);
    put_event(EV_PRESS, 8'($urandom_range(0, 255)), btn);
  endtask

  task automatic lift_button(input logic [1:0] btn);
    put_event(EV_RELEASE, 8'($urandom_range(0, 255)), btn);
  endtask

  // Transfers run back to back; the caller drops psel after the last one.
  task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Checked at a falling edge so the checker's count has settled.
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Every event yields at least one word, so an empty expectation queue means idle.
  task automatic program_regs(input logic [15:0] ack, input logic [15:0] hold,
                              input logic [15:0] dark, input logic [15:0] fin,
                              input logic [7:0] blink);
    in_ch.valid <= 1'b0;
    wait_drained();
    ack_set  = ack;
    long_set = hold;
    end_set  = fin;
    apb_access(1'b1, REG_ACK_TIMEOUT, {16'd0, ack});
    apb_access(1'b1, REG_LONG_PRESS,  {16'd0, hold});
    apb_access(1'b1, REG_DARK_START,  {16'd0, dark});
    apb_access(1'b1, REG_CONFIG_END,  {16'd0, fin});
    apb_access(1'b1, REG_BLINK_HALF,  {24'd0, blink});
    apb_access(1'b0, REG_ACK_TIMEOUT, '0);
    apb_access(1'b0, REG_LONG_PRESS,  '0);
    apb_access(1'b0, REG_DARK_START,  '0);
    apb_access(1'b0, REG_CONFIG_END,  '0);
    apb_access(1'b0, REG_BLINK_HALF,  '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Command byte, then confirm, cancel, timeout or a stray byte and confirm.
  task automatic run_command();
    logic [7:0] c;
    int         r;
    if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 1) ? CH_T : CH_F;
    else c = command_char($urandom_range(0, 16));
    send_byte(c);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_byte(CH_T);
      // a confirmed report request keeps waiting: ask again, then cancel
      if (c == CH_U) begin
        send_byte(CH_T);
        send_byte(CH_F);
      end
    end else if (r < 60) begin
      send_byte(CH_F);
    end else if (r < 80) begin
      repeat (capped(int'(ack_set) + 1, 30)) send_tick();
    end else begin
      send_byte(command_char($urandom_range(0, 16)));
      send_byte(CH_T);
    end
  endtask

  // Hold the outer buttons (setup mode if long_set <= 40), then try to leave setup.
  task automatic run_setup();
    int n;
    if (!btn_down[0]) push_button(2'd0);
    if (!btn_down[3]) push_button(2'd3);
    if (btn_down[1]) lift_button(2'd1);
    if (btn_down[2]) lift_button(2'd2);
    n = (long_set <= 16'd40) ? int'(long_set) + $urandom_range(0, 1) : $urandom_range(1, 5);
    repeat (n) send_tick();
    repeat ($urandom_range(0, 6)) send_tick();
    if ($urandom_range(0, 3) == 0) push_button(2'($urandom_range(0, 3)));
    case ($urandom_range(0, 3))
      0: send_byte(CH_T);
      1: send_byte(CH_F);
      2: repeat (capped(int'(end_set) + 4, 40)) send_tick();
      default: begin
        send_byte(command_char($urandom_range(0, 16)));
        send_byte(CH_T);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      lift_button(2'd0);
      lift_button(2'd3);
    end
  endtask

  // Random touches, including repeated presses and releases.
  task automatic run_buttons();
    logic [1:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 2'($urandom_range(0, 3));
      if (btn_down[b] && $urandom_range(0, 3) != 0) lift_button(b);
      else if (!btn_down[b] && $urandom_range(0, 4) == 0) lift_button(b);
      else push_button(b);
    end
  endtask

  initial begin
    int target;
    int r;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= EV_BYTE;
    in_ch.rx_byte <= '0;
    in_ch.button  <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset register values.
    push_button(2'd0);
    push_button(2'd3);
    send_tick();             // outer-button hold starts counting
    lift_button(2'd3);       // button 0 still down: no report
    lift_button(2'd0);       // all up: report
    push_button(2'd1);
    push_button(2'd2);
    lift_button(2'd1);
    lift_button(2'd2);
    lift_button(2'd2);       // release of a button already up reports again
    send_byte(8'hFF);        // not a command: ignored
    send_byte(CH_T);         // confirm with nothing waiting: held only
    send_byte(CH_G);
    send_byte(CH_T);         // all four relays on
    send_byte(CH_0);
    send_byte(8'h00);        // stray byte while waiting
    send_byte(CH_F);         // cancel
    send_byte(CH_E);
    send_byte(CH_T);
    send_byte(CH_U);
    send_byte(CH_T);         // report, still waiting
    send_byte(CH_F);
    send_byte(CH_0 + 8'd5);
    send_tick();
    send_tick();
    send_tick();
    // Pending command survives the register change below: the lowered
    // ack timeout must expire it on the first tick of the next phase.

    target = events_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(16'd1, 16'd1, 16'd1, 16'd1, 8'd1);
        1: program_regs(16'd4, 16'd3, 16'd6, 16'd10, 8'd2);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        3: program_regs(16'd6, 16'd2, 16'd12, 16'd22, 8'd4);
        4: program_regs(16'($urandom_range(1, 40)), 16'($urandom_range(1, 10)),
                        16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
                        8'($urandom_range(1, 8)));
        default: program_regs(16'd20, 16'd1500, 16'd30000, 16'd32000, 8'd200);
      endcase
      calm <= (p == 3);      // one whole phase without gaps or stalls
      target += PHASE_ITEMS;
      while (events_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 30) run_command();
        else if (r < 55) run_setup();
        else if (r < 80) run_buttons();
        else put_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       2'($urandom_range(0, 3)));
      end
    end

    in_ch.valid <= 1'b0;
    calm <= 1'b0;
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("Summary: %0d events over %0d register settings, %0d result words checked,",
             events_sent, NUM_PHASES + 1, words_checked);
    $display("         %0d entries into setup mode", setup_entries);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(20_000_000);
    $display("Timeout with %0d result words still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
